[hw/rtl/hgrp_pkg.sv]
package hgrp_pkg;

  // byte classes found by the front end
  typedef struct packed {
    logic [7:0] lc;       // lower-cased byte
    logic       is_sp;
    logic       is_cr;
    logic       is_lf;
    logic       is_digit;
    logic       is_lws;   // space, tab, VT, FF
    logic       restart;
  } cls_t;

  typedef struct packed {
    cls_t       cls;
    logic [7:0] raw;
  } q_item_t;

  typedef enum logic [9:0] {
    PH_METHOD  = 10'b0000000001,
    PH_SP1     = 10'b0000000010,
    PH_URL     = 10'b0000000100,
    PH_SP2     = 10'b0000001000,
    PH_VERSION = 10'b0000010000,
    PH_DEAD    = 10'b0000100000,
    PH_NAME    = 10'b0001000000,
    PH_VALUE   = 10'b0010000000,
    PH_SKIP    = 10'b0100000000,
    PH_BODY    = 10'b1000000000
  } phase_t;

  localparam logic [1:0] ST_BUSY = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;
  localparam logic [1:0] ST_LONG = 2'd3;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_URL  = 2'd1;
  localparam logic [1:0] KIND_HOST = 2'd2;
  localparam logic [1:0] KIND_BODY = 2'd3;

  localparam logic [1:0] HDR_NONE = 2'd0;
  localparam logic [1:0] HDR_CONN = 2'd1;
  localparam logic [1:0] HDR_CLEN = 2'd2;
  localparam logic [1:0] HDR_HOST = 2'd3;

  localparam logic [1:0] URL_START = 2'd0;
  localparam logic [1:0] URL_PFX   = 2'd1;
  localparam logic [1:0] URL_HOST  = 2'd2;
  localparam logic [1:0] URL_PATH  = 2'd3;

  localparam logic [15:0] LIMIT_RESET = 16'd2048;

  function automatic logic [7:0] ch_get(input logic [4:0] i);
    case (i)
      5'd0: ch_get = "g";
      5'd1: ch_get = "e";
      5'd2: ch_get = "t";
      default: ch_get = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] ch_ver(input logic [4:0] i);
    case (i)
      5'd0: ch_ver = "h";
      5'd1: ch_ver = "t";
      5'd2: ch_ver = "t";
      5'd3: ch_ver = "p";
      5'd4: ch_ver = "/";
      5'd5: ch_ver = "1";
      5'd6: ch_ver = ".";
      5'd7: ch_ver = "1";
      default: ch_ver = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] ch_pfx(input logic [4:0] i);
    case (i)
      5'd0: ch_pfx = "h";
      5'd1: ch_pfx = "t";
      5'd2: ch_pfx = "t";
      5'd3: ch_pfx = "p";
      5'd4: ch_pfx = ":";
      5'd5: ch_pfx = "/";
      5'd6: ch_pfx = "/";
      default: ch_pfx = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] ch_ka(input logic [4:0] i);
    case (i)
      5'd0: ch_ka = "k";
      5'd1: ch_ka = "e";
      5'd2: ch_ka = "e";
      5'd3: ch_ka = "p";
      5'd4: ch_ka = "-";
      5'd5: ch_ka = "a";
      5'd6: ch_ka = "l";
      5'd7: ch_ka = "i";
      5'd8: ch_ka = "v";
      5'd9: ch_ka = "e";
      default: ch_ka = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] ch_conn(input logic [4:0] i);
    case (i)
      5'd0: ch_conn = "c";
      5'd1: ch_conn = "o";
      5'd2: ch_conn = "n";
      5'd3: ch_conn = "n";
      5'd4: ch_conn = "e";
      5'd5: ch_conn = "c";
      5'd6: ch_conn = "t";
      5'd7: ch_conn = "i";
      5'd8: ch_conn = "o";
      5'd9: ch_conn = "n";
      5'd10: ch_conn = ":";
      default: ch_conn = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] ch_clen(input logic [4:0] i);
    case (i)
      5'd0: ch_clen = "c";
      5'd1: ch_clen = "o";
      5'd2: ch_clen = "n";
      5'd3: ch_clen = "t";
      5'd4: ch_clen = "e";
      5'd5: ch_clen = "n";
      5'd6: ch_clen = "t";
      5'd7: ch_clen = "-";
      5'd8: ch_clen = "l";
      5'd9: ch_clen = "e";
      5'd10: ch_clen = "n";
      5'd11: ch_clen = "g";
      5'd12: ch_clen = "t";
      5'd13: ch_clen = "h";
      5'd14: ch_clen = ":";
      default: ch_clen = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] ch_host(input logic [4:0] i);
    case (i)
      5'd0: ch_host = "h";
      5'd1: ch_host = "o";
      5'd2: ch_host = "s";
      5'd3: ch_host = "t";
      5'd4: ch_host = ":";
      default: ch_host = 8'h00;
    endcase
  endfunction

endpackage

[hw/rtl/hgrp_front.sv]
module hgrp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_restart,
  output logic              q_valid,
  input  logic              q_ready,
  output hgrp_pkg::q_item_t q_item
);
  import hgrp_pkg::*;

  q_item_t item_c;

  always_comb begin
    item_c.raw          = in_byte;
    item_c.cls.lc       = (in_byte >= "A" && in_byte <= "Z") ? in_byte + 8'd32 : in_byte;
    item_c.cls.is_sp    = (in_byte == " ");
    item_c.cls.is_cr    = (in_byte == 8'h0d);
    item_c.cls.is_lf    = (in_byte == 8'h0a);
    item_c.cls.is_digit = (in_byte >= "0" && in_byte <= "9");
    item_c.cls.is_lws   = (in_byte == " ") || (in_byte == 8'h09) ||
                          (in_byte == 8'h0b) || (in_byte == 8'h0c);
    item_c.cls.restart  = in_restart;
  end

  // single register stage, full throughput unless q_ready stalls it
  assign in_ready = !q_valid || q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      q_item <= item_c;
    end
  end
endmodule

[hw/rtl/hgrp_queue.sv]
module hgrp_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  hgrp_pkg::q_item_t wr_item,
  output logic              rd_valid,
  input  logic              rd_ready,
  output hgrp_pkg::q_item_t rd_item
);
  import hgrp_pkg::*;

  q_item_t    slot [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign wr_ready = (cnt != 2'd2);
  assign rd_valid = (cnt != 2'd0);
  assign rd_item  = slot[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) wp <= ~wp;
      if (rd_valid && rd_ready) rp <= ~rp;
      cnt <= cnt + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) slot[wp] <= wr_item;
  end

`ifndef SYNTHESIS
  a_no_over: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("queue count overflow");
  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2 && !rd_ready) |=> cnt == 2'd2)
    else $error("full queue lost an item");
  a_empty_hold: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd0 && !wr_valid) |=> cnt == 2'd0)
    else $error("empty queue invented an item");
`endif
endmodule

[hw/rtl/hgrp_back.sv]
module hgrp_back #(
  parameter int LENGTH_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [15:0]       limit,
  input  logic              q_valid,
  output logic              q_ready,
  input  hgrp_pkg::q_item_t q_item,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [7:0]        out_byte,
  output logic [1:0]        out_kind,
  output logic              out_keep,
  output logic [31:0]       out_len
);
  import hgrp_pkg::*;

  localparam logic [LENGTH_BITS-1:0] LMAX = '1;
  localparam logic [LENGTH_BITS-1:0] LDIV = LMAX / 10;
  localparam logic [3:0] LREM = 4'(LMAX % 10);

  phase_t               phase, phase_n;
  logic [4:0]           pos, pos_n;
  logic [3:0]           mflags, mflags_n;
  logic                 cr, cr_n;
  logic [1:0]           umode, umode_n;
  logic [1:0]           hkind, hkind_n;
  logic                 linger, linger_n;
  logic [LENGTH_BITS-1:0] lval, lval_n, body, body_n;
  logic [15:0]          seen, seen_n;
  logic [1:0]           done, done_n;
  logic [1:0]           kind;

  logic take;
  assign q_ready = !out_valid || out_ready;
  assign take    = q_valid && q_ready;

  // stored values with restart applied
  phase_t               phase_s;
  logic [4:0]           pos_s;
  logic [3:0]           mflags_s;
  logic                 cr_s, linger_s;
  logic [1:0]           umode_s, hkind_s, done_s;
  logic [LENGTH_BITS-1:0] lval_s, body_s;
  logic [15:0]          seen_s;

  logic [7:0] lc;
  logic [3:0] dig;
  logic [LENGTH_BITS-1:0] digv;
  logic [4:0] posb;
  logic [3:0] mf;

  always_comb begin
    lc = q_item.cls.lc;
    dig = q_item.raw[3:0];
    digv = LENGTH_BITS'(dig);
    if (q_item.cls.restart) begin
      phase_s = PH_METHOD; pos_s = '0; mflags_s = 4'hf; cr_s = 1'b0;
      umode_s = URL_START; hkind_s = HDR_NONE; linger_s = 1'b0;
      lval_s = '0; body_s = '0; seen_s = '0; done_s = ST_BUSY;
    end else begin
      phase_s = phase; pos_s = pos; mflags_s = mflags; cr_s = cr;
      umode_s = umode; hkind_s = hkind; linger_s = linger;
      lval_s = lval; body_s = body; seen_s = seen; done_s = done;
    end
    phase_n = phase_s; pos_n = pos_s; mflags_n = mflags_s; cr_n = cr_s;
    umode_n = umode_s; hkind_n = hkind_s; linger_n = linger_s;
    lval_n = lval_s; body_n = body_s; seen_n = seen_s; done_n = done_s;
    kind = KIND_NONE;
    posb = (pos_s < 5'd31) ? pos_s + 5'd1 : pos_s;
    mf = mflags_s;

    if (done_s == ST_BUSY) begin
      if (seen_s >= limit) begin
        done_n = ST_LONG;
      end else begin
        seen_n = seen_s + 16'd1;
        if (phase_s == PH_BODY) begin
          kind = KIND_BODY;
          body_n = body_s + 1'b1;
          if (body_n >= lval_s) done_n = ST_DONE;
        end else if (cr_s) begin
          cr_n = 1'b0;
          if (!q_item.cls.is_lf) begin
            done_n = ST_BAD;
          end else if (phase_s inside {PH_METHOD, PH_SP1, PH_URL, PH_SP2, PH_VERSION,
                                       PH_DEAD}) begin
            if (phase_s == PH_VERSION && pos_s == 5'd8) begin
              phase_n = PH_NAME; pos_n = '0; mflags_n = 4'hf; hkind_n = HDR_NONE;
            end else begin
              done_n = ST_BAD;
            end
          end else if (phase_s == PH_NAME && pos_s == 5'd0) begin
            if (lval_s != '0) begin
              phase_n = PH_BODY; body_n = '0;
            end else begin
              done_n = ST_DONE;
            end
          end else begin
            if (phase_s == PH_VALUE && hkind_s == HDR_CONN && mflags_s[0] &&
                pos_s == 5'd10) linger_n = 1'b1;
            phase_n = PH_NAME; pos_n = '0; mflags_n = 4'hf; hkind_n = HDR_NONE;
          end
        end else if (q_item.cls.is_cr) begin
          cr_n = 1'b1;
        end else if (q_item.cls.is_lf) begin
          done_n = ST_BAD;
        end else begin
          case (phase_s)
            PH_METHOD: begin
              if (q_item.cls.is_sp) begin
                phase_n = (pos_s == 5'd3 && mflags_s[0]) ? PH_SP1 : PH_DEAD;
              end else begin
                if (pos_s >= 5'd3 || lc != ch_get(pos_s)) mflags_n[0] = 1'b0;
                pos_n = posb;
              end
            end
            PH_SP1, PH_URL: begin
              logic [1:0] um;
              logic [4:0] up;
              um = (phase_s == PH_SP1) ? URL_START : umode_s;
              up = (phase_s == PH_SP1) ? 5'd0 : pos_s;
              if (phase_s == PH_SP1 && q_item.cls.is_sp) begin
                // stay
              end else begin
                phase_n = PH_URL; umode_n = um; pos_n = up;
                if (q_item.cls.is_sp) begin
                  phase_n = (um == URL_PATH) ? PH_SP2 : PH_DEAD;
                end else begin
                  case (um)
                    URL_START: begin
                      if (q_item.raw == "/") begin
                        umode_n = URL_PATH; kind = KIND_URL;
                      end else if (lc == "h") begin
                        umode_n = URL_PFX; pos_n = 5'd1;
                      end else begin
                        phase_n = PH_DEAD;
                      end
                    end
                    URL_PFX: begin
                      if (up < 5'd7 && lc == ch_pfx(up)) begin
                        pos_n = up + 5'd1;
                        if (up == 5'd6) umode_n = URL_HOST;
                      end else begin
                        phase_n = PH_DEAD;
                      end
                    end
                    URL_HOST: begin
                      if (q_item.raw == "/") begin
                        umode_n = URL_PATH; kind = KIND_URL;
                      end
                    end
                    default: kind = KIND_URL;
                  endcase
                end
              end
            end
            PH_SP2, PH_VERSION: begin
              logic [4:0] vp;
              vp = (phase_s == PH_SP2) ? 5'd0 : pos_s;
              if (phase_s == PH_SP2 && q_item.cls.is_sp) begin
                // stay
              end else begin
                phase_n = PH_VERSION;
                if (vp < 5'd8 && lc == ch_ver(vp)) pos_n = vp + 5'd1;
                else begin
                  pos_n = vp; phase_n = PH_DEAD;
                end
              end
            end
            PH_NAME: begin
              if (mf[0] && !(pos_s < 5'd11 && lc == ch_conn(pos_s))) mf[0] = 1'b0;
              if (mf[1] && !(pos_s < 5'd15 && lc == ch_clen(pos_s))) mf[1] = 1'b0;
              if (mf[2] && !(pos_s < 5'd5 && lc == ch_host(pos_s))) mf[2] = 1'b0;
              mflags_n = mf; pos_n = posb;
              if (mf[0] && posb == 5'd11) begin
                hkind_n = HDR_CONN; phase_n = PH_VALUE; pos_n = '0; mflags_n = 4'hf;
              end else if (mf[1] && posb == 5'd15) begin
                hkind_n = HDR_CLEN; phase_n = PH_VALUE; pos_n = '0; mflags_n = 4'hf;
                lval_n = '0;
              end else if (mf[2] && posb == 5'd5) begin
                hkind_n = HDR_HOST; phase_n = PH_VALUE; pos_n = '0; mflags_n = 4'hf;
              end else if (mf[2:0] == 3'b000) begin
                phase_n = PH_SKIP;
              end
            end
            PH_VALUE: begin
              case (hkind_s)
                HDR_CONN: begin
                  if (!(pos_s == 5'd0 && q_item.cls.is_sp)) begin
                    if (mflags_s[0] && pos_s < 5'd10 && lc == ch_ka(pos_s))
                      pos_n = pos_s + 5'd1;
                    else mflags_n[0] = 1'b0;
                  end
                end
                HDR_CLEN: begin
                  // saturating decimal accumulate: overflow compare against LDIV and LREM, one multiply-add
                  logic [LENGTH_BITS-1:0] acc;
                  acc = (lval_s > LDIV || (lval_s == LDIV && dig > LREM)) ? LMAX :
                        lval_s * LENGTH_BITS'(10) + digv;
                  if (pos_s == 5'd0) begin
                    if (!q_item.cls.is_lws) begin
                      if (q_item.cls.is_digit) begin
                        lval_n = acc; pos_n = 5'd1;
                      end else pos_n = 5'd2;
                    end
                  end else if (pos_s == 5'd1) begin
                    if (q_item.cls.is_digit) lval_n = acc;
                    else pos_n = 5'd2;
                  end
                end
                HDR_HOST: begin
                  if (!(pos_s == 5'd0 && q_item.cls.is_sp)) begin
                    pos_n = 5'd1; kind = KIND_HOST;
                  end
                end
                default: ;
              endcase
            end
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_METHOD; pos <= '0; mflags <= 4'hf; cr <= 1'b0;
      umode <= URL_START; hkind <= HDR_NONE; linger <= 1'b0;
      lval <= '0; body <= '0; seen <= '0; done <= ST_BUSY;
      out_valid <= 1'b0;
    end else begin
      if (q_ready) out_valid <= q_valid;
      if (take) begin
        phase <= phase_n; pos <= pos_n; mflags <= mflags_n; cr <= cr_n;
        umode <= umode_n; hkind <= hkind_n; linger <= linger_n;
        lval <= lval_n; body <= body_n; seen <= seen_n; done <= done_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_status <= done_n;
      out_byte   <= q_item.raw;
      out_kind   <= kind;
      out_keep   <= linger_n;
      out_len    <= 32'(lval_n);
    end
  end

`ifndef SYNTHESIS
  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (take && !q_item.cls.restart && done != ST_BUSY) |=> done == $past(done))
    else $error("finished status changed");
  a_body_kind: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == KIND_BODY) |-> !cr)
    else $error("body byte while CR pending");
  a_seen_limit: assert property (@(posedge clk) disable iff (rst)
    (take && done_n == ST_BUSY) |-> seen_n <= limit)
    else $error("byte count past limit while busy");
`endif
endmodule

[hw/rtl/http_get_request_parser_top.sv]
// HTTP GET request parser, one byte per item.
// Path from input accept to result valid: classify register, queue slot,
//   execute register; queue adds up to 2 items of slack.
// Throughput: 1 item per cycle while m_tready does not stall it, set by the back-end state update.
// Reset (rst, synchronous): parser state cleared, byte limit back to 2048.
module http_get_request_parser_top #(
  parameter int LENGTH_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: request_byte_limit
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // [7:0] data_byte
  input  logic        s_tuser,  // [0] restart
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,  // [1:0] status, [9:2] out_byte, [10] keep_alive,
                                // [42:11] body_length, [47:43] zero
  output logic [1:0]  m_tuser   // [1:0] byte_kind
);
  import hgrp_pkg::*;

  logic [15:0] limit;
  always_ff @(posedge clk) begin
    if (rst) limit <= LIMIT_RESET;
    else if (cfg_we) limit <= cfg_data;
  end

  // front end: classify and register
  logic    f_valid, f_ready;
  q_item_t f_item;
  hgrp_front u_front (
    .clk, .rst, .in_valid(s_tvalid), .in_ready(s_tready),
    .in_byte(s_tdata), .in_restart(s_tuser),
    .q_valid(f_valid), .q_ready(f_ready), .q_item(f_item)
  );

  // short queue decouples the two halves
  logic    b_valid, b_ready;
  q_item_t b_item;
  hgrp_queue u_queue (
    .clk, .rst, .wr_valid(f_valid), .wr_ready(f_ready), .wr_item(f_item),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_item(b_item)
  );

  // back end: parser state machine with output register
  logic [1:0]  st, kd;
  logic [7:0]  ob;
  logic        ka;
  logic [31:0] bl;
  hgrp_back #(.LENGTH_BITS(LENGTH_BITS)) u_back (
    .clk, .rst, .limit, .q_valid(b_valid), .q_ready(b_ready), .q_item(b_item),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_status(st), .out_byte(ob),
    .out_kind(kd), .out_keep(ka), .out_len(bl)
  );

  assign m_tdata = {5'd0, bl, ka, ob, st};
  assign m_tuser = kd;
endmodule
